### design/lkvc_pkg.sv
// Package for the LRU key/value cache: payload types, field widths and mode codes.
// It depends on nothing; the store and the top level import it.
package lkvc_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 31;
	localparam int CAP_W = 5;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [CAP_W-1:0] cap_t;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_SET = 1'b1;

	// Write strobes from the sequencer to the key and value memories.
	typedef struct packed {
		logic key_we;
		logic val_we;
	} lkvc_wr_t;

endpackage

### design/lkvc_store.sv
// Key and value memories of the LRU key/value cache, one write and one read port each.
// It depends on lkvc_pkg for the payload types and the write strobe struct.
module lkvc_store #(
	parameter int ENTRIES = 16
) (
	input  logic                                          clk,
	input  logic                                          rd_en,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
	output lkvc_pkg::key_t                                rd_key,
	output lkvc_pkg::val_t                                rd_val,
	input  lkvc_pkg::lkvc_wr_t                            wr,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
	input  lkvc_pkg::key_t                                wr_key,
	input  lkvc_pkg::val_t                                wr_val
);
	import lkvc_pkg::*;

	key_t key_mem [ENTRIES];
	val_t val_mem [ENTRIES];
	key_t rd_key_q;
	val_t rd_val_q;

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr.val_we) begin
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	assign rd_key = rd_key_q;
	assign rd_val = rd_val_q;

endmodule

### design/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Each item is scanned entry by entry until the entry that hits, or to the last entry
// on a miss; the update state follows, and a get result is registered there.
// The next item is taken only after the update of the last one; all scans use the single
// key comparator. A get holds in its update cycle while the previous result is stalled.
// Reset (arst_n low) clears valid bits, ranks, occupancy and outputs; capacity resets to 16.
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              capacity_we,
	input  lkvc_pkg::cap_t    capacity_wdata,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              mode,
	input  lkvc_pkg::key_t    key,
	input  lkvc_pkg::val_t    value,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              found,
	output lkvc_pkg::val_t    read_value
);
	import lkvc_pkg::*;

	// Entry index and rank width, scan counter width (it must also hold ENTRIES),
	// and a common width for comparing the occupancy with the capacity register.
	localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Sequencer states. The block takes an item only in idle. The scan walks the entries
	// up to a hit or the last one through the one shared key comparator; the update cycle
	// then applies the recency change, eviction, insertion and the result.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0]     state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IW-1:0]  idx_s1;
	logic           cmp_vld_s1;

	// The accepted item.
	logic           mode_q;
	key_t           key_q;
	val_t           value_q;

	// What the scan learns: the hit, the least recent valid entry and the first free slot.
	logic           hit_q;
	logic [IW-1:0]  hit_idx_q;
	val_t           hit_val_q;
	logic           vic_found_q;
	logic [IW-1:0]  vic_idx_q;
	logic [IW-1:0]  vic_rank_q;
	logic           free_found_q;
	logic [IW-1:0]  free_idx_q;

	// Per-entry bookkeeping in flip-flops. Rank 0 is the most recent entry.
	logic           valid_q [ENTRIES];
	logic [IW-1:0]  rank_q  [ENTRIES];
	logic [CNT_W-1:0] used_q;
	cap_t           cap_q;

	logic           out_valid_q;
	logic           found_q;
	val_t           read_value_q;

	// Memory interface.
	logic           rd_en;
	key_t           rd_key;
	val_t           rd_val;
	lkvc_wr_t       wr;
	logic [IW-1:0]  wr_addr;

	logic           accept;
	logic           scan_hit;
	logic           scan_done;
	logic           cmp_valid;
	logic [IW-1:0]  cmp_rank;
	logic           go;
	logic           is_get;
	logic [EW-1:0]  eff_cap;
	logic           evict;
	logic [IW-1:0]  slot;
	logic [IW-1:0]  touch_rank;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);

	assign rd_en = (state_q == ST_SCAN) && (cnt_q != CNT_W'(ENTRIES));

	// Compare stage of the scan: the registered read data belongs to entry idx_s1.
	assign cmp_valid = valid_q[idx_s1];
	assign cmp_rank  = rank_q[idx_s1];
	assign scan_hit  = cmp_vld_s1 && cmp_valid && (rd_key == key_q);
	// The last entry is compared in the cycle in which the counter reads ENTRIES.
	assign scan_done = (cnt_q == CNT_W'(ENTRIES));

	// A get with a result still waiting downstream holds in the update state.
	assign is_get = (mode_q == MODE_GET);
	assign go     = (state_q == ST_UPDATE) && !(is_get && out_valid_q && rsp_stall);

	// Capacity zero acts as one; a capacity above the entry count saturates.
	always_comb begin
		eff_cap = EW'(cap_q);
		if (cap_q == '0) begin
			eff_cap = EW'(1);
		end else if (EW'(cap_q) > EW'(ENTRIES)) begin
			eff_cap = EW'(ENTRIES);
		end
	end

	assign evict = (EW'(used_q) >= eff_cap);

	// The new entry goes to the lowest free slot once the victim has been freed.
	always_comb begin
		slot = free_idx_q;
		if (evict) begin
			if (free_found_q && (free_idx_q < vic_idx_q)) begin
				slot = free_idx_q;
			end else begin
				slot = vic_idx_q;
			end
		end
	end

	assign touch_rank = rank_q[hit_idx_q];

	// Memory writes happen only in the update cycle of a set: the value on a hit,
	// key and value on an insertion.
	always_comb begin
		wr.key_we = go && (mode_q == MODE_SET) && !hit_q;
		wr.val_we = go && (mode_q == MODE_SET);
		wr_addr   = hit_q ? hit_idx_q : slot;
	end

	lkvc_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (cnt_q[IW-1:0]),
		.rd_key  (rd_key),
		.rd_val  (rd_val),
		.wr      (wr),
		.wr_addr (wr_addr),
		.wr_key  (key_q),
		.wr_val  (value_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(16);
		end else if (capacity_we) begin
			cap_q <= capacity_wdata;
		end
	end

	// Sequencer and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_hit || scan_done) begin
						state_q <= ST_UPDATE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_UPDATE: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item capture and scan results; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= cnt_q[IW-1:0];
		end
		if (accept) begin
			mode_q       <= mode;
			key_q        <= key;
			value_q      <= value;
			hit_q        <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && cmp_vld_s1) begin
			if (scan_hit) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_val_q <= rd_val;
			end
			// Ties go to the later index, as ranks of valid entries are distinct anyway.
			if (cmp_valid && (!vic_found_q || (cmp_rank >= vic_rank_q))) begin
				vic_found_q <= 1'b1;
				vic_idx_q   <= idx_s1;
				vic_rank_q  <= cmp_rank;
			end
			if (!cmp_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
	end

	// Recency ranks, valid bits and occupancy change only in the update cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
			used_q <= '0;
		end else if (go) begin
			if (hit_q) begin
				// Touch: entries more recent than the hit move back one place.
				for (int i = 0; i < ENTRIES; i++) begin
					if (IW'(i) == hit_idx_q) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < touch_rank)) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
			end else if (mode_q == MODE_SET) begin
				// Insertion, after evicting the least recent entry when full.
				for (int i = 0; i < ENTRIES; i++) begin
					if (IW'(i) == slot) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (evict && (IW'(i) == vic_idx_q)) begin
						valid_q[i] <= 1'b0;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
				if (!evict) begin
					used_q <= used_q + CNT_W'(1);
				end
			end
		end
	end

	// Output register: a get leaves its result here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			read_value_q <= '0;
		end else begin
			if (go && is_get) begin
				out_valid_q  <= 1'b1;
				found_q      <= hit_q;
				read_value_q <= hit_q ? hit_val_q : '0;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = out_valid_q;
	assign found      = found_q;
	assign read_value = read_value_q;

endmodule

### sim/testbench.sv
// Self-checking testbench for lru_key_value_cache: directed and random get/set items,
// predicted by an in-bench LRU shadow of the cache and checked one response at a time.
// Depends on design/lkvc_pkg.sv, design/lkvc_store.sv and design/lru_key_value_cache.sv.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lkvc_pkg::*;

	// Geometry of the instance and pacing of the run.
	localparam int SLOTS = 16;
	// Cycles to let a set finish its scan and update before a capacity write.
	// A set leaves no response.
	localparam int SETTLE = SLOTS + 8;
	// Quiet cycles at the end, once every expected response has come back.
	localparam int TAIL = 2 * SLOTS + 8;
	// Cycles with no handshake at all before the run is declared hung.
	localparam int STALL_LIMIT = 1000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 200;

	// What one get should return.
	typedef struct packed {
		logic found;
		val_t read_value;
	} lookup_t;

	// Shadow copy of the cache: the same entries, valid bits, recency ranks and occupancy
	// the block keeps, updated for every accepted item. Gets queue their predicted
	// response; responses from the block are checked against the oldest one.
	class cache_mirror;
		key_t keys [SLOTS];
		val_t vals [SLOTS];
		bit live [SLOTS];
		int unsigned rank [SLOTS];
		int unsigned used;
		cap_t capacity;
		lookup_t pending_lookups [$];
		int mismatches;

		function new();
			foreach (live[i]) begin
				live[i] = 1'b0;
				rank[i] = 0;
			end
			used = 0;
			capacity = cap_t'(16);
			mismatches = 0;
		endfunction

		function void set_capacity(cap_t c);
			capacity = c;
		endfunction

		// Zero acts as one, anything above the entry count saturates.
		function int effective_capacity();
			int c;
			c = capacity;
			if (c == 0)
				c = 1;
			if (c > SLOTS)
				c = SLOTS;
			return c;
		endfunction

		function int pending();
			return pending_lookups.size();
		endfunction

		// Move an entry to the front; everything that was ahead of it slips back one place.
		function void promote(int h);
			int unsigned r;
			r = rank[h];
			foreach (live[i])
				if (live[i] && rank[i] < r)
					rank[i]++;
			rank[h] = 0;
		endfunction

		function void note_request(logic m, key_t k, val_t v);
			int hit;
			int victim;
			int slot;
			int unsigned worst;
			lookup_t r;
			hit = -1;
			foreach (live[i])
				if (hit < 0 && live[i] && keys[i] == k)
					hit = i;
			if (m == MODE_GET) begin
				r.found = (hit >= 0);
				r.read_value = (hit >= 0) ? vals[hit] : '0;
				if (hit >= 0)
					promote(hit);
				pending_lookups.push_back(r);
			end else if (hit >= 0) begin
				vals[hit] = v;
				promote(hit);
			end else begin
				// A full cache drops its least recent entry first. A capacity lowered
				// below the occupancy drops only one entry per miss, so it never shrinks.
				if (used >= effective_capacity()) begin
					victim = -1;
					worst = 0;
					foreach (live[i]) begin
						if (live[i] && (victim < 0 || rank[i] >= worst)) begin
							worst = rank[i];
							victim = i;
						end
					end
					if (victim >= 0) begin
						live[victim] = 1'b0;
						rank[victim] = 0;
						if (used > 0)
							used--;
					end
				end
				slot = -1;
				foreach (live[i])
					if (slot < 0 && !live[i])
						slot = i;
				if (slot >= 0) begin
					foreach (live[i])
						if (live[i])
							rank[i]++;
					keys[slot] = k;
					vals[slot] = v;
					live[slot] = 1'b1;
					rank[slot] = 0;
					used++;
				end
			end
		endfunction

		function void check_lookup(logic f, val_t rv);
			lookup_t want;
			if (pending_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response with no get outstanding: %s%0b read_value=%h",
						$realtime, "found=", f, rv);
				return;
			end
			want = pending_lookups.pop_front();
			if (f !== want.found || rv !== want.read_value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: get mismatch: expected found=%0b read_value=%h,",
						$realtime, want.found, want.read_value,
						" got found=%0b read_value=%h", f, rv);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic capacity_we;
	cap_t capacity_wdata;
	logic req_valid;
	logic req_stall;
	logic mode;
	key_t key;
	val_t value;
	logic rsp_valid;
	logic rsp_stall;
	logic found;
	val_t read_value;

	// When set, that side runs back to back with no idle cycles for the current phase.
	bit req_calm;
	bit rsp_calm;

	cache_mirror mirror;

	always #5 clk = ~clk;

	lru_key_value_cache #(
		.ENTRIES(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.key(key),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.found(found),
		.read_value(read_value)
	);

	// Offer one item and return at the edge that accepts it. Valid is left high so that
	// a following item with no gap goes out back to back; the next call with a gap, a capacity
	// write or the end of the run lowers it. Outputs are read just after the edge, so
	// they still hold the values the block saw at that edge.
	task automatic issue_request(input logic m, input key_t k, input val_t v);
		int gap;
		gap = req_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		key <= k;
		value <= v;
		do @(posedge clk); while (req_stall !== 1'b0);
		mirror.note_request(m, k, v);
	endtask

	// Capacity changes only while the cache is idle: no get outstanding and enough
	// cycles gone by for a trailing set to finish its scan and update.
	task automatic write_capacity(input cap_t c);
		req_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		capacity_we <= 1'b1;
		capacity_wdata <= c;
		@(posedge clk);
		capacity_we <= 1'b0;
		mirror.set_capacity(c);
	endtask

	// Random traffic over a small key pool sized a little above the capacity, so that
	// hits, updates, misses and evictions all come up often. One item in ten takes a
	// fresh random key, which almost always misses.
	task automatic run_random_phase(input int count);
		key_t pool [24];
		int pool_n;
		logic m;
		key_t k;
		val_t v;
		pool_n = mirror.effective_capacity() + $urandom_range(0, 6);
		foreach (pool[i])
			pool[i] = $urandom;
		// Extreme keys join the pool now and then.
		if ($urandom_range(0, 1) == 0)
			pool[0] = 32'h8000_0000;
		if ($urandom_range(0, 1) == 0)
			pool[1] = 32'h7FFF_FFFF;
		if ($urandom_range(0, 2) == 0)
			pool[2] = 32'h0000_0000;
		if ($urandom_range(0, 2) == 0)
			pool[3] = 32'hFFFF_FFFF;
		req_calm = ($urandom_range(0, 3) == 0);
		rsp_calm = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			m = ($urandom_range(0, 1) == 0) ? MODE_GET : MODE_SET;
			if ($urandom_range(0, 9) == 0)
				k = $urandom;
			else
				k = pool[$urandom_range(0, pool_n - 1)];
			case ($urandom_range(0, 15))
				0: v = '0;
				1: v = '1;
				default: v = val_t'($urandom);
			endcase
			issue_request(m, k, v);
		end
	endtask

	// Response side: stall for a random number of cycles, then take the next response
	// and hand it to the mirror for checking.
	initial begin : response_sink
		int n;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = rsp_calm ? 0 : $urandom_range(0, 6);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			mirror.check_lookup(found, read_value);
		end
	end

	// Hang detector: any accepted item, response or capacity write restarts the count.
	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid === 1'b1 && req_stall === 1'b0) ||
				(rsp_valid === 1'b1 && rsp_stall === 1'b0) || capacity_we === 1'b1)
				idle = 0;
			else
				idle++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		cap_t phase_caps [PHASES];
		mirror = new();
		req_calm = 1'b0;
		rsp_calm = 1'b0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		mode <= MODE_GET;
		key <= '0;
		value <= '0;
		capacity_we <= 1'b0;
		capacity_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity of 16: a get on the empty cache, extreme keys and values,
		// an update of a present key, and a miss among present entries.
		issue_request(MODE_GET, 32'h0000_0000, '0);
		issue_request(MODE_SET, 32'h8000_0000, 31'h7FFF_FFFF);
		issue_request(MODE_SET, 32'h7FFF_FFFF, 31'h0000_0000);
		issue_request(MODE_GET, 32'h8000_0000, 31'h7FFF_FFFF);
		issue_request(MODE_GET, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
		issue_request(MODE_SET, 32'hFFFF_FFFF, 31'h0000_0001);
		issue_request(MODE_SET, 32'hFFFF_FFFF, 31'h2AAA_AAAA);
		issue_request(MODE_GET, 32'hFFFF_FFFF, '0);
		issue_request(MODE_GET, 32'h0000_0000, 31'h5555_5555);

		// Capacity lowered below the three entries in use: the next miss drops only
		// the least recent key and occupancy stays at three.
		write_capacity(cap_t'(2));
		issue_request(MODE_SET, 32'h0000_0000, 31'h5555_5555);
		issue_request(MODE_GET, 32'h8000_0000, '0);
		issue_request(MODE_GET, 32'h7FFF_FFFF, '0);
		issue_request(MODE_GET, 32'h0000_0000, '0);

		// A capacity of zero acts as one.
		write_capacity(cap_t'(0));
		issue_request(MODE_SET, 32'h1234_5678, 31'h0123_4567);
		issue_request(MODE_SET, 32'h0000_0001, 31'h7654_3210);
		issue_request(MODE_GET, 32'h1234_5678, '0);
		issue_request(MODE_GET, 32'h0000_0001, '0);

		// A capacity above the entry count saturates.
		write_capacity(cap_t'(31));
		issue_request(MODE_SET, 32'hDEAD_BEEF, 31'h3C3C_3C3C);
		issue_request(MODE_GET, 32'hDEAD_BEEF, '0);

		// Random phases, each under its own capacity; the last one is drawn at random.
		phase_caps = '{cap_t'(1), cap_t'(16), cap_t'(4), cap_t'(31), cap_t'(0),
			cap_t'(8), cap_t'(2), cap_t'(15), cap_t'(17), cap_t'(0)};
		phase_caps[PHASES - 1] = cap_t'($urandom_range(0, 31));
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_caps[p]);
			run_random_phase(PHASE_ITEMS);
		end

		// Drain: every get answered, then a quiet tail to catch stray responses.
		req_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
design/lkvc_pkg.sv
design/lkvc_store.sv
design/lru_key_value_cache.sv
sim/testbench.sv
